FILE: rtl/step_pulse_train_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Step pulse train generator assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STEP_PULSE_TRAIN_GENERATOR_TOP_MACROS_SVH
`define STEP_PULSE_TRAIN_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPTG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sptg check failed: same-cycle implication");

// next-cycle implication
`define SPTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sptg check failed: next-cycle implication");

`endif

FILE: rtl/sptg_pkg.sv
// ----------------------------------------------------------------------------
// sptg_pkg
// Widths, codes and control/status bundles of the step pulse train generator.
// ----------------------------------------------------------------------------
package sptg_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int PERIOD_WIDTH = 16;
    localparam int DATA_W       = 32;
    localparam int SCALE_W      = 16;
    localparam int DUR_W        = 16;
    localparam int PROD_W       = SCALE_W + DUR_W;
    localparam int STEP_W       = $clog2(PROD_W);

    localparam logic [SCALE_W-1:0]      SCALE_RESET  = SCALE_W'(1000);
    localparam logic [PERIOD_WIDTH-1:0] RELOAD_RESET = '1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_QUEUE = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_APPLY,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic apply;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fall_seg;
        logic div_done;
    } sts_t;

endpackage

FILE: rtl/sptg_div.sv
// ----------------------------------------------------------------------------
// sptg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sptg_div
    import sptg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [PROD_W-1:0]      dividend,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [PROD_W-1:0]      quotient
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_W - 1);

    logic                   busy_reg, busy_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;
    logic [PROD_W-1:0]      quo_reg, quo_next;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        done      = busy_reg && (cnt_reg == STEP_LAST);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits COUNT_WIDTH bits
            rem_next = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign quotient = quo_reg;

endmodule

FILE: rtl/sptg_datapath.sv
// ----------------------------------------------------------------------------
// sptg_datapath
// Pulse state, segment queue, period math and result register.
// ----------------------------------------------------------------------------
module sptg_datapath
    import sptg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic                     cfg_wr_en,
    input  logic [SCALE_W-1:0]       cfg_wr_data,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] delta,
    input  logic [DUR_W-1:0]         duration,
    input  logic [PERIOD_WIDTH-1:0]  start_period,
    output logic                     pulse_out,
    output logic                     busy_res,
    output logic signed [DATA_W-1:0] remaining,
    output logic [PERIOD_WIDTH-1:0]  period_now,
    output logic                     segment_taken
);

    logic [SCALE_W-1:0]      scale_reg;
    logic                    running_reg, running_next;
    logic                    level_reg, level_next;
    logic [COUNT_WIDTH-1:0]  target_reg, target_next;
    logic [PERIOD_WIDTH-1:0] reload_reg, reload_next;
    logic [PERIOD_WIDTH-1:0] tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0]  pend_delta_reg, pend_delta_next;
    logic [DUR_W-1:0]        pend_dur_reg, pend_dur_next;
    logic                    taken_reg, taken_next;

    logic                    out_level_reg;
    logic                    out_running_reg;
    logic [COUNT_WIDTH-1:0]  out_target_reg;
    logic [PERIOD_WIDTH-1:0] out_reload_reg;
    logic                    out_taken_reg;

    logic [PERIOD_WIDTH-1:0] tick_inc;
    logic                    fire;
    logic                    pend_ok;
    logic [COUNT_WIDTH-1:0]  in_count;
    logic [COUNT_WIDTH-1:0]  target_mag;
    logic [COUNT_WIDTH-1:0]  target_stepped;
    logic [PROD_W-1:0]       product;
    logic [PROD_W-1:0]       quotient;
    logic [PERIOD_WIDTH-1:0] new_reload;
    logic                    div_done;

    sptg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .dividend (product),
        .divisor  (target_mag),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_RESET;
            running_reg    <= 1'b0;
            level_reg      <= 1'b0;
            target_reg     <= '0;
            reload_reg     <= RELOAD_RESET;
            tick_reg       <= '0;
            pend_delta_reg <= '0;
            pend_dur_reg   <= '0;
            taken_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            running_reg    <= running_next;
            level_reg      <= level_next;
            target_reg     <= target_next;
            reload_reg     <= reload_next;
            tick_reg       <= tick_next;
            pend_delta_reg <= pend_delta_next;
            pend_dur_reg   <= pend_dur_next;
            taken_reg      <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_level_reg   <= level_reg;
            out_running_reg <= running_reg;
            out_target_reg  <= target_reg;
            out_reload_reg  <= reload_reg;
            out_taken_reg   <= taken_reg;
        end
    end

    always_comb
    begin
        tick_inc       = tick_reg + 1'b1;
        fire           = running_reg && (mode_t'(mode) == MODE_TICK) && (tick_inc >= reload_reg);
        pend_ok        = (pend_delta_reg != '0) && (pend_dur_reg != '0);
        in_count       = delta[COUNT_WIDTH-1:0];
        target_mag     = target_reg[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - target_reg) : target_reg;
        // step one toward zero
        target_stepped = target_reg[COUNT_WIDTH-1] ? (target_reg + 1'b1) : (target_reg - 1'b1);
        product        = PROD_W'(scale_reg) * PROD_W'(pend_dur_reg);
        new_reload     = quotient[PERIOD_WIDTH-1:0];

        sts.fall_seg   = fire && level_reg && pend_ok;
        sts.div_done   = div_done;

        running_next    = running_reg;
        level_next      = level_reg;
        target_next     = target_reg;
        reload_next     = reload_reg;
        tick_next       = tick_reg;
        pend_delta_next = pend_delta_reg;
        pend_dur_next   = pend_dur_reg;
        taken_next      = taken_reg;

        if (cmd.accept)
        begin
            taken_next = 1'b0;
            case (mode_t'(mode))
                MODE_TICK:
                begin
                    if (running_reg)
                    begin
                        tick_next = tick_inc;
                        if (fire)
                        begin
                            tick_next = '0;
                            if (level_reg)
                            begin
                                level_next = 1'b0;
                                if (pend_ok)
                                begin
                                    // rest of the fall runs after the divide
                                    taken_next  = 1'b1;
                                    target_next = target_reg + pend_delta_reg;
                                end
                                else if (target_reg == '0)
                                begin
                                    running_next = 1'b0;
                                end
                                else
                                begin
                                    target_next = target_stepped;
                                end
                            end
                            else
                            begin
                                level_next = 1'b1;
                            end
                        end
                    end
                end
                MODE_QUEUE:
                begin
                    pend_delta_next = in_count;
                    pend_dur_next   = duration;
                end
                MODE_START:
                begin
                    target_next  = in_count;
                    reload_next  = start_period;
                    tick_next    = '0;
                    level_next   = 1'b0;
                    running_next = (in_count != '0);
                end
                default:
                begin
                    running_next = 1'b0;
                    level_next   = 1'b0;
                    tick_next    = '0;
                end
            endcase
        end

        if (cmd.apply)
        begin
            pend_delta_next = '0;
            pend_dur_next   = '0;
            if ((target_reg == '0) || (new_reload == '0))
            begin
                running_next = 1'b0;
                level_next   = 1'b0;
                tick_next    = '0;
            end
            else
            begin
                reload_next = new_reload;
                tick_next   = '0;
                target_next = target_stepped;
            end
        end
    end

    assign pulse_out     = out_level_reg;
    assign busy_res      = out_running_reg;
    assign remaining     = DATA_W'($signed(out_target_reg));
    assign period_now    = out_reload_reg;
    assign segment_taken = out_taken_reg;

endmodule

FILE: rtl/sptg_ctrl.sv
// ----------------------------------------------------------------------------
// sptg_ctrl
// Request sequencing: accept, optional period divide, result hand-off.
// ----------------------------------------------------------------------------
module sptg_ctrl
    import sptg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.fall_seg ? ST_LOAD : ST_FIN;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait here only while the previous result is still unread
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/step_pulse_train_generator_top.sv
// ----------------------------------------------------------------------------
// step_pulse_train_generator_top
// One-channel step pulse generator driven by tick/queue/start/stop requests.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | in_valid / in_ready    | mode, delta, duration, start_period
//   result   | out_valid / out_ready  | pulse_out, busy_res, remaining,
//            |                        | period_now, segment_taken
//   config   | cfg_wr_en              | cfg_wr_data (cycle scale)
//
// Most requests go through accept, then load of the result register.
// A falling edge that consumes a queued segment adds load, divide and apply; the
// period is scale*duration/|remaining| from a 1-bit-per-cycle divider (32 steps).
// The input side waits in the hand-off state while the result register is full.
// Reset: asynchronous, active low; cycle scale returns to 1000.
// ----------------------------------------------------------------------------
module step_pulse_train_generator_top
    import sptg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [SCALE_W-1:0]       cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] delta,
    input  logic [DUR_W-1:0]         duration,
    input  logic [PERIOD_WIDTH-1:0]  start_period,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     pulse_out,
    output logic                     busy_res,
    output logic signed [DATA_W-1:0] remaining,
    output logic [PERIOD_WIDTH-1:0]  period_now,
    output logic                     segment_taken
);

    cmd_t cmd;
    sts_t sts;

    sptg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sptg_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mode          (mode),
        .delta         (delta),
        .duration      (duration),
        .start_period  (start_period),
        .pulse_out     (pulse_out),
        .busy_res      (busy_res),
        .remaining     (remaining),
        .period_now    (period_now),
        .segment_taken (segment_taken)
    );

endmodule

FILE: rtl/sptg_checker.sv
// ----------------------------------------------------------------------------
// sptg_checker
// Port-level checks of the step pulse train generator.
// ----------------------------------------------------------------------------
`include "step_pulse_train_generator_top_macros.svh"

module sptg_checker
    import sptg_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     pulse_out,
    input logic                     busy_res,
    input logic signed [DATA_W-1:0] remaining,
    input logic [PERIOD_WIDTH-1:0]  period_now,
    input logic                     segment_taken
);

    // a held result keeps its count
    `SPTG_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(remaining))

    // the pulse is only high while running
    `SPTG_ASSERT_SAME(a_level_needs_run, out_valid && !busy_res, !pulse_out)

    // a segment is taken only on a falling edge
    `SPTG_ASSERT_SAME(a_taken_on_fall, out_valid && segment_taken, !pulse_out)

    // a taken segment that keeps running installed a nonzero period
    `SPTG_ASSERT_SAME(a_taken_period, out_valid && segment_taken && busy_res, period_now != '0)

endmodule

bind step_pulse_train_generator_top sptg_checker u_sptg_checker (.*);
